// ----- hdl/msq_pkg.sv -----
// ----------------------------------------------------------------------------
// msq_pkg: shared types and constants for the marching squares cell core
// Item structs, edge codes, segment table and grid constants.
// ----------------------------------------------------------------------------
package msq_pkg;

	localparam int ROW_COUNT  = 64;
	localparam int COL_COUNT  = 64;
	localparam int VALUE_BITS = 16;
	localparam int FRAC_BITS  = 8;
	localparam int IDX_BITS   = 6;
	localparam int POS_BITS   = 14;
	localparam int QUO_BITS   = FRAC_BITS + 1;
	localparam int NUM_EDGES  = 4;

	localparam logic [IDX_BITS+1:0] ROW_LAST = (IDX_BITS+2)'(ROW_COUNT - 1);
	localparam logic [IDX_BITS+1:0] COL_LAST = (IDX_BITS+2)'(COL_COUNT - 1);
	localparam logic [QUO_BITS-1:0] ONE_CELL = QUO_BITS'(1 << FRAC_BITS);

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [POS_BITS-1:0]   pos_t;
	typedef logic [QUO_BITS-1:0]   frac_t;

	typedef enum logic [1:0] {
		EDGE_LEFT   = 2'd0,
		EDGE_RIGHT  = 2'd1,
		EDGE_TOP    = 2'd2,
		EDGE_BOTTOM = 2'd3
	} edge_t;

	typedef struct packed {
		logic [IDX_BITS-1:0] row_index;
		logic [IDX_BITS-1:0] col_index;
		value_t              corner_base;
		value_t              corner_next_row;
		value_t              corner_next_col;
		value_t              corner_diagonal;
	} cell_t;

	typedef struct packed {
		pos_t start_row_pos;
		pos_t start_col_pos;
		pos_t end_row_pos;
		pos_t end_col_pos;
		logic last_segment;
	} seg_t;

	typedef struct packed {
		logic [1:0] nseg;
		edge_t      a0;
		edge_t      b0;
		edge_t      a1;
		edge_t      b1;
	} plan_t;

	function automatic plan_t seg_plan(input logic [3:0] idx);
		plan_t p;
		p = '{nseg: 2'd1, a0: EDGE_LEFT, b0: EDGE_LEFT, a1: EDGE_LEFT, b1: EDGE_LEFT};
		unique case (idx)
			4'd0, 4'd15: p.nseg = 2'd0;
			4'd1, 4'd14: begin p.a0 = EDGE_LEFT;   p.b0 = EDGE_BOTTOM; end
			4'd2, 4'd13: begin p.a0 = EDGE_BOTTOM; p.b0 = EDGE_RIGHT;  end
			4'd3, 4'd12: begin p.a0 = EDGE_LEFT;   p.b0 = EDGE_RIGHT;  end
			4'd4, 4'd11: begin p.a0 = EDGE_TOP;    p.b0 = EDGE_RIGHT;  end
			4'd6, 4'd9:  begin p.a0 = EDGE_TOP;    p.b0 = EDGE_BOTTOM; end
			4'd7, 4'd8:  begin p.a0 = EDGE_LEFT;   p.b0 = EDGE_TOP;    end
			4'd5: begin
				p.nseg = 2'd2;
				p.a0 = EDGE_LEFT;   p.b0 = EDGE_TOP;
				p.a1 = EDGE_BOTTOM; p.b1 = EDGE_RIGHT;
			end
			default: begin
				p.nseg = 2'd2;
				p.a0 = EDGE_LEFT; p.b0 = EDGE_BOTTOM;
				p.a1 = EDGE_TOP;  p.b1 = EDGE_RIGHT;
			end
		endcase
		return p;
	endfunction

	// Grid position of index plus fraction, held at the last grid line.
	function automatic pos_t coord(input logic [IDX_BITS:0] idx, input frac_t f,
			input logic [IDX_BITS+1:0] last);
		logic [POS_BITS+3:0] p;
		logic [POS_BITS+3:0] lim;
		p   = ((POS_BITS+4)'(idx) << FRAC_BITS) + (POS_BITS+4)'(f);
		lim = (POS_BITS+4)'(last) << FRAC_BITS;
		if (p > lim) p = lim;
		return p[POS_BITS-1:0];
	endfunction

endpackage

// ----- hdl/msq_divider.sv -----
// ----------------------------------------------------------------------------
// msq_divider: pipelined restoring divider for one edge fraction
// Computes min((n << FRAC_BITS) / d, one cell), one quotient bit per stage.
// ----------------------------------------------------------------------------
module msq_divider (
	input  logic                         clk,
	input  logic                         adv,
	input  msq_pkg::value_t              num,
	input  msq_pkg::value_t              den,
	output msq_pkg::frac_t               quo
);
	localparam int QB = msq_pkg::QUO_BITS;
	localparam int VB = msq_pkg::VALUE_BITS;

	// Stage k holds remainder, divisor and quotient bits found so far.
	logic [VB:0]   rem_s [QB+1];
	msq_pkg::value_t den_s [QB+1];
	logic [QB-1:0] q_s   [QB+1];

	always_comb begin
		rem_s[0] = {1'b0, num};
		den_s[0] = den;
		q_s[0]   = '0;
	end

	// The quotient can be at most 2^FRAC_BITS only when num <= den, which
	// holds on every edge a segment uses; the clamp keeps other edges sane.
	for (genvar k = 0; k < QB; k++) begin : g_bit
		logic [VB+1:0] shifted;
		logic [VB:0]   r_next;
		logic          qb;
		always_comb begin
			if (k == 0) shifted = {1'b0, rem_s[k]};
			else        shifted = {rem_s[k], 1'b0};
			qb     = shifted >= {2'b00, den_s[k]};
			r_next = qb ? (VB+1)'(shifted - {2'b00, den_s[k]}) : shifted[VB:0];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1] <= r_next;
				den_s[k+1] <= den_s[k];
				q_s[k+1]   <= {q_s[k][QB-2:0], qb};
			end
		end
	end

	assign quo = (q_s[QB] > msq_pkg::ONE_CELL) ? msq_pkg::ONE_CELL : q_s[QB];
endmodule

// ----- hdl/msq_out_queue.sv -----
// ----------------------------------------------------------------------------
// msq_out_queue: output skid queue for segment items
// Four-entry FIFO; reports room for the items still in flight upstream.
// ----------------------------------------------------------------------------
module msq_out_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  msq_pkg::seg_t  push_data,
	output logic           almost_full,
	output logic           out_valid,
	input  logic           out_ready,
	output msq_pkg::seg_t  out_data
);
	msq_pkg::seg_t mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic pop;

	assign pop = out_valid && out_ready;
	assign out_valid = cnt_q != 3'd0;
	assign out_data = mem_q[rd_q];
	assign almost_full = cnt_q >= 3'd3;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end
endmodule

// ----- hdl/marching_squares_cell_core.sv -----
// ----------------------------------------------------------------------------
// marching_squares_cell_core: marching squares isoline segment generator
// Classifies one grid cell per item and emits its contour segments.
// ----------------------------------------------------------------------------
// Usage: cells enter on in_valid/in_ready with a cell_t payload; segments
// leave on out_valid/out_ready as seg_t items, one or two per cell, the last
// one flagged by last_segment. A cell whose four corners all lie on the same
// side of the level produces no item.
// The level register is written on cfg_valid/cfg_ready (always ready) and
// must only change while the block is idle.
// Stage 1 thresholds corners and forms edge numerators and divisors, nine
// divider stages (one quotient bit each) follow, and a final stage forms
// coordinates and writes the output queue.
// A cell enters every cycle while the pipeline moves; a saddle cell stalls
// the input while its second segment is written, so the output channel sets
// the sustained rate. The pipeline advances as one unit; it stalls
// when a segment is waiting in the second slot or the output queue lacks
// room, and nothing is lost or repeated.
// Reset clears the valid bits and the queue and loads level with 32768.
// ----------------------------------------------------------------------------
module marching_squares_cell_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  msq_pkg::cell_t        in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output msq_pkg::seg_t         out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  msq_pkg::value_t       cfg_data
);
	localparam int DEPTH = msq_pkg::QUO_BITS;
	localparam int IB = msq_pkg::IDX_BITS;

	msq_pkg::value_t level_q;
	logic adv, almost_full, push;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) level_q <= msq_pkg::value_t'(32768);
		else if (cfg_valid) level_q <= cfg_data;
	end

	// Stage 1: case index, segment plan and edge divider operands.
	msq_pkg::plan_t plan_c;
	logic [3:0] idx_c;
	msq_pkg::value_t num_c [msq_pkg::NUM_EDGES];
	msq_pkg::value_t den_c [msq_pkg::NUM_EDGES];

	function automatic logic [2*msq_pkg::VALUE_BITS-1:0] edge_ops(
			input msq_pkg::value_t v0, input msq_pkg::value_t v1,
			input msq_pkg::value_t t);
		msq_pkg::value_t n, d;
		// Zero numerator yields fraction zero; zero divisor is forced likewise.
		if (v1 > v0) begin
			d = v1 - v0;
			n = (t > v0) ? t - v0 : '0;
		end else begin
			d = v0 - v1;
			n = (v0 > t) ? v0 - t : '0;
		end
		if (d == '0) begin
			n = '0;
			d = msq_pkg::value_t'(1);
		end
		return {n, d};
	endfunction

	always_comb begin
		idx_c = {in_data.corner_base > level_q, in_data.corner_next_row > level_q,
			in_data.corner_diagonal > level_q, in_data.corner_next_col > level_q};
		plan_c = msq_pkg::seg_plan(idx_c);
		{num_c[msq_pkg::EDGE_LEFT], den_c[msq_pkg::EDGE_LEFT]} =
			edge_ops(in_data.corner_base, in_data.corner_next_col, level_q);
		{num_c[msq_pkg::EDGE_RIGHT], den_c[msq_pkg::EDGE_RIGHT]} =
			edge_ops(in_data.corner_next_row, in_data.corner_diagonal, level_q);
		{num_c[msq_pkg::EDGE_TOP], den_c[msq_pkg::EDGE_TOP]} =
			edge_ops(in_data.corner_base, in_data.corner_next_row, level_q);
		{num_c[msq_pkg::EDGE_BOTTOM], den_c[msq_pkg::EDGE_BOTTOM]} =
			edge_ops(in_data.corner_next_col, in_data.corner_diagonal, level_q);
	end

	msq_pkg::value_t num_s1 [msq_pkg::NUM_EDGES];
	msq_pkg::value_t den_s1 [msq_pkg::NUM_EDGES];
	msq_pkg::plan_t plan_s1;
	logic [IB-1:0] row_s1, col_s1;
	logic vld_s1;

	// Busy second slot: a saddle's second segment waiting for the queue.
	logic pend_q;
	msq_pkg::seg_t pend_seg_q;

	assign adv = !almost_full && !pend_q;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= in_valid && (plan_c.nseg != 2'd0);
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1 <= num_c;
			den_s1 <= den_c;
			plan_s1 <= plan_c;
			row_s1 <= in_data.row_index;
			col_s1 <= in_data.col_index;
		end
	end

	msq_pkg::frac_t frac [msq_pkg::NUM_EDGES];
	for (genvar e = 0; e < msq_pkg::NUM_EDGES; e++) begin : g_div
		msq_divider u_div (
			.clk(clk), .adv(adv), .num(num_s1[e]), .den(den_s1[e]), .quo(frac[e])
		);
	end

	// Side band travelling alongside the divider stages.
	logic vld_d [DEPTH+1];
	msq_pkg::plan_t plan_d [DEPTH+1];
	logic [IB-1:0] row_d [DEPTH+1];
	logic [IB-1:0] col_d [DEPTH+1];
	always_comb begin
		vld_d[0] = vld_s1;
		plan_d[0] = plan_s1;
		row_d[0] = row_s1;
		col_d[0] = col_s1;
	end
	for (genvar k = 0; k < DEPTH; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_d[k+1] <= 1'b0;
			else if (adv) vld_d[k+1] <= vld_d[k];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				plan_d[k+1] <= plan_d[k];
				row_d[k+1] <= row_d[k];
				col_d[k+1] <= col_d[k];
			end
		end
	end

	// Final stage: coordinates of every edge point, then segment assembly.
	msq_pkg::pos_t er [msq_pkg::NUM_EDGES];
	msq_pkg::pos_t ec [msq_pkg::NUM_EDGES];
	msq_pkg::plan_t pl;
	msq_pkg::seg_t seg0_c, seg1_c;
	logic [IB:0] r0, c0;

	always_comb begin
		pl = plan_d[DEPTH];
		r0 = {1'b0, row_d[DEPTH]};
		c0 = {1'b0, col_d[DEPTH]};
		er[msq_pkg::EDGE_LEFT]   = msq_pkg::coord(r0, '0, msq_pkg::ROW_LAST);
		ec[msq_pkg::EDGE_LEFT]   = msq_pkg::coord(c0, frac[msq_pkg::EDGE_LEFT],
			msq_pkg::COL_LAST);
		er[msq_pkg::EDGE_RIGHT]  = msq_pkg::coord(r0 + 1'b1, '0, msq_pkg::ROW_LAST);
		ec[msq_pkg::EDGE_RIGHT]  = msq_pkg::coord(c0, frac[msq_pkg::EDGE_RIGHT],
			msq_pkg::COL_LAST);
		er[msq_pkg::EDGE_TOP]    = msq_pkg::coord(r0, frac[msq_pkg::EDGE_TOP],
			msq_pkg::ROW_LAST);
		ec[msq_pkg::EDGE_TOP]    = msq_pkg::coord(c0, '0, msq_pkg::COL_LAST);
		er[msq_pkg::EDGE_BOTTOM] = msq_pkg::coord(r0, frac[msq_pkg::EDGE_BOTTOM],
			msq_pkg::ROW_LAST);
		ec[msq_pkg::EDGE_BOTTOM] = msq_pkg::coord(c0 + 1'b1, '0, msq_pkg::COL_LAST);
		seg0_c = '{er[pl.a0], ec[pl.a0], er[pl.b0], ec[pl.b0], pl.nseg == 2'd1};
		seg1_c = '{er[pl.a1], ec[pl.a1], er[pl.b1], ec[pl.b1], 1'b1};
	end

	logic fire;
	assign fire = adv && vld_d[DEPTH];
	assign push = fire || pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= 1'b0;
		else if (pend_q) pend_q <= 1'b0;
		else if (fire && pl.nseg == 2'd2) pend_q <= 1'b1;
	end
	always_ff @(posedge clk) begin
		if (fire) pend_seg_q <= seg1_c;
	end

	msq_out_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push),
		.push_data(pend_q ? pend_seg_q : seg0_c), .almost_full(almost_full),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// A pending second segment always lands in the queue the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) pend_q |=> !pend_q)
		else $error("second segment held more than one cycle");
	// Input is never taken while the second segment is pending.
	assert property (@(posedge clk) disable iff (!arst_n) pend_q |-> !in_ready)
		else $error("input accepted during second segment");
	// A saddle's first segment is never flagged as last.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && pl.nseg == 2'd2) |-> !seg0_c.last_segment)
		else $error("saddle first segment marked last");
endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for marching_squares_cell_core
// Drives grid cells through the valid/ready input channel under several iso
// levels, predicts each cell's contour segments and compares every output item.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_CELLS = 1250;
	localparam int PIPE_DRAIN = 40;

	typedef struct {
		msq_pkg::cell_t cell_item;
		bit             typed;
		int             count;
		msq_pkg::seg_t  first;
	} stim_row_t;

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_ready;
	msq_pkg::cell_t  in_data;
	logic            out_valid;
	logic            out_ready;
	msq_pkg::seg_t   out_data;
	logic            cfg_valid;
	logic            cfg_ready;
	msq_pkg::value_t cfg_data;

	msq_pkg::value_t iso_level;
	msq_pkg::seg_t   seg_expect_q[$];
	msq_pkg::seg_t   first_pred;
	int              mismatch_count;
	int              segment_count;
	int              cell_count;
	longint          cycle_count;
	bit              stall_enable;
	stim_row_t       stim_rows[$];

	marching_squares_cell_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Truncated fraction of the edge from v0 to v1 at which the level lies.
	function automatic int unsigned edge_crossing(int unsigned v0, int unsigned v1,
			int unsigned lvl);
		longint n;
		longint d;
		longint f;
		n = longint'(lvl) - longint'(v0);
		d = longint'(v1) - longint'(v0);
		if (d == 0) return 0;
		if (d < 0) begin
			n = -n;
			d = -d;
		end
		if (n <= 0) return 0;
		f = (n << msq_pkg::FRAC_BITS) / d;
		return (f > (1 << msq_pkg::FRAC_BITS)) ? (1 << msq_pkg::FRAC_BITS) : 32'(f);
	endfunction

	function automatic msq_pkg::pos_t grid_pos(int unsigned idx, int unsigned frac,
			int unsigned count);
		int unsigned p;
		int unsigned lim;
		p = (idx << msq_pkg::FRAC_BITS) + frac;
		lim = (count - 1) << msq_pkg::FRAC_BITS;
		if (p > lim) p = lim;
		return msq_pkg::pos_t'(p);
	endfunction

	// Appends the segments of one cell at the current level to the queue.
	function automatic int predict_segments(msq_pkg::cell_t c);
		logic [3:0]     case_idx;
		msq_pkg::pos_t  er[msq_pkg::NUM_EDGES];
		msq_pkg::pos_t  ec[msq_pkg::NUM_EDGES];
		msq_pkg::edge_t ends[4];
		int             nseg;
		msq_pkg::seg_t  s;
		case_idx = {c.corner_base > iso_level, c.corner_next_row > iso_level,
			c.corner_diagonal > iso_level, c.corner_next_col > iso_level};
		nseg = 1;
		case (case_idx)
			4'd0, 4'd15: nseg = 0;
			4'd1, 4'd14: begin
				ends[0] = msq_pkg::EDGE_LEFT;   ends[1] = msq_pkg::EDGE_BOTTOM;
			end
			4'd2, 4'd13: begin
				ends[0] = msq_pkg::EDGE_BOTTOM; ends[1] = msq_pkg::EDGE_RIGHT;
			end
			4'd3, 4'd12: begin
				ends[0] = msq_pkg::EDGE_LEFT;   ends[1] = msq_pkg::EDGE_RIGHT;
			end
			4'd4, 4'd11: begin
				ends[0] = msq_pkg::EDGE_TOP;    ends[1] = msq_pkg::EDGE_RIGHT;
			end
			4'd6, 4'd9: begin
				ends[0] = msq_pkg::EDGE_TOP;    ends[1] = msq_pkg::EDGE_BOTTOM;
			end
			4'd7, 4'd8: begin
				ends[0] = msq_pkg::EDGE_LEFT;   ends[1] = msq_pkg::EDGE_TOP;
			end
			4'd5: begin
				nseg = 2;
				ends[0] = msq_pkg::EDGE_LEFT;   ends[1] = msq_pkg::EDGE_TOP;
				ends[2] = msq_pkg::EDGE_BOTTOM; ends[3] = msq_pkg::EDGE_RIGHT;
			end
			default: begin
				nseg = 2;
				ends[0] = msq_pkg::EDGE_LEFT; ends[1] = msq_pkg::EDGE_BOTTOM;
				ends[2] = msq_pkg::EDGE_TOP;  ends[3] = msq_pkg::EDGE_RIGHT;
			end
		endcase
		if (nseg == 0) return 0;
		er[msq_pkg::EDGE_LEFT]   = grid_pos(c.row_index, 0, msq_pkg::ROW_COUNT);
		ec[msq_pkg::EDGE_LEFT]   = grid_pos(c.col_index,
			edge_crossing(c.corner_base, c.corner_next_col, iso_level), msq_pkg::COL_COUNT);
		er[msq_pkg::EDGE_RIGHT]  = grid_pos(c.row_index + 1, 0, msq_pkg::ROW_COUNT);
		ec[msq_pkg::EDGE_RIGHT]  = grid_pos(c.col_index,
			edge_crossing(c.corner_next_row, c.corner_diagonal, iso_level),
			msq_pkg::COL_COUNT);
		er[msq_pkg::EDGE_TOP]    = grid_pos(c.row_index,
			edge_crossing(c.corner_base, c.corner_next_row, iso_level), msq_pkg::ROW_COUNT);
		ec[msq_pkg::EDGE_TOP]    = grid_pos(c.col_index, 0, msq_pkg::COL_COUNT);
		er[msq_pkg::EDGE_BOTTOM] = grid_pos(c.row_index,
			edge_crossing(c.corner_next_col, c.corner_diagonal, iso_level),
			msq_pkg::ROW_COUNT);
		ec[msq_pkg::EDGE_BOTTOM] = grid_pos(c.col_index + 1, 0, msq_pkg::COL_COUNT);
		for (int k = 0; k < nseg; k++) begin
			s.start_row_pos = er[ends[2*k]];
			s.start_col_pos = ec[ends[2*k]];
			s.end_row_pos   = er[ends[2*k+1]];
			s.end_col_pos   = ec[ends[2*k+1]];
			s.last_segment  = (k == nseg - 1);
			if (k == 0) first_pred = s;
			seg_expect_q = {seg_expect_q, s};
		end
		return nseg;
	endfunction

	function automatic msq_pkg::value_t rand_value();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return msq_pkg::value_t'(iso_level + $urandom_range(0, 2) - 1);
			default: return msq_pkg::value_t'($urandom);
		endcase
	endfunction

	function automatic msq_pkg::cell_t rand_cell();
		msq_pkg::cell_t c;
		c.row_index = ($urandom_range(0, 15) == 0) ? 6'($urandom) : 6'($urandom_range(0, 62));
		c.col_index = ($urandom_range(0, 15) == 0) ? 6'($urandom) : 6'($urandom_range(0, 62));
		c.corner_base     = rand_value();
		c.corner_next_row = rand_value();
		c.corner_next_col = rand_value();
		c.corner_diagonal = rand_value();
		return c;
	endfunction

	task automatic write_level(msq_pkg::value_t lvl);
		cfg_valid <= 1'b1;
		cfg_data  <= lvl;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		iso_level = lvl;
	endtask

	// Offers one cell; a burst gap of the length the caller gives is inserted before it.
	task automatic send_cell(msq_pkg::cell_t c, int gap, output int produced);
		repeat (gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= c;
		do @(posedge clk); while (!in_ready);
		produced = predict_segments(c);
		cell_count++;
	endtask

	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (seg_expect_q.size() != 0) @(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	task automatic add_row(logic [5:0] r, logic [5:0] c, msq_pkg::value_t b,
			msq_pkg::value_t nr, msq_pkg::value_t nc, msq_pkg::value_t d, bit typed,
			int count, msq_pkg::seg_t first);
		stim_row_t row;
		row.cell_item = '{row_index: r, col_index: c, corner_base: b, corner_next_row: nr,
			corner_next_col: nc, corner_diagonal: d};
		row.typed = typed;
		row.count = count;
		row.first = first;
		stim_rows = {stim_rows, row};
	endtask

	// Output side: receiver stall pattern and comparison against the queue.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				segment_count++;
				if (seg_expect_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10) $display("unexpected segment %p", out_data);
				end else begin
					msq_pkg::seg_t want;
					want = seg_expect_q.pop_front();
					if (want !== out_data) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("segment mismatch: expected %p, got %p", want, out_data);
					end
				end
			end
			out_ready <= !stall_enable || (cycle_count % 7 < 4) || ($urandom_range(0, 2) == 0);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		msq_pkg::value_t level_set[5];
		int              burst;
		int              gap;
		int              n;
		int              produced;
		bit              ok;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		iso_level = 16'd32768;
		mismatch_count = 0;
		segment_count = 0;
		cell_count = 0;
		cycle_count = 0;
		stall_enable = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows at the reset level; typed results are easy to read off.
		add_row(0, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 0, '0);
		add_row(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0, '0);
		// Only base above, halfway on both edges: left to top.
		add_row(0, 0, 16'hFFFF, 16'h0001, 16'h0001, 16'h0001, 0, 1, '0);
		add_row(1, 2, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 0, 1, '0);
		add_row(3, 4, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 0, 1, '0);
		add_row(5, 6, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 0, 1, '0);
		add_row(7, 8, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 0, 1, '0);
		add_row(9, 10, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 0, 1, '0);
		add_row(11, 12, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 0, 2, '0);
		add_row(13, 14, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 1, '0);
		add_row(15, 16, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 0, 1, '0);
		add_row(17, 18, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 0, 2, '0);
		add_row(19, 20, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 0, 1, '0);
		add_row(21, 22, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 0, 1, '0);
		add_row(23, 24, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 0, 1, '0);
		// Corner exactly at the level counts as below.
		add_row(25, 26, 16'h8000, 16'h8001, 16'h8000, 16'h8000, 0, 1, '0);
		// Cells at the grid edge: points past the last grid line saturate at it.
		add_row(62, 62, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 0, 1, '0);
		add_row(63, 63, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1, 1,
			'{start_row_pos: 14'd16128, start_col_pos: 14'd16128,
			  end_row_pos: 14'd16128, end_col_pos: 14'd16128, last_segment: 1'b1});
		add_row(63, 0, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 0, 1, '0);
		add_row(0, 63, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 0, 1, '0);

		foreach (stim_rows[i]) begin
			send_cell(stim_rows[i].cell_item, 0, produced);
			if (stim_rows[i].typed) begin
				ok = (produced == stim_rows[i].count);
				if (stim_rows[i].count > 0 && first_pred !== stim_rows[i].first)
					ok = 0;
				if (!ok) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("directed row %0d: predictor disagrees with table", i);
				end
			end
		end
		drain_pipe();

		level_set = '{16'h0000, 16'hFFFF, 16'h0001, 16'h1234, 16'h8000};
		stall_enable = 1'b1;
		foreach (level_set[p]) begin
			write_level(level_set[p]);
			n = 0;
			while (n < RANDOM_CELLS / 5) begin
				burst = $urandom_range(1, 30);
				for (int j = 0; j < burst && n < RANDOM_CELLS / 5; j++) begin
					gap = (j == 0 && p != 2) ? $urandom_range(0, 6) : 0;
					send_cell(rand_cell(), gap, produced);
					n++;
				end
			end
			drain_pipe();
			stall_enable = (p % 2 == 0);
		end

		$display("%0d cells sent over 6 iso levels, %0d segments checked",
			cell_count, segment_count);
		if (mismatch_count == 0 && seg_expect_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches, %0d segments still expected",
				mismatch_count, seg_expect_q.size());
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
